### src/block_index_linked_queue_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the block index linked queue
// Shorthand for clocked checks, disabled while reset is asserted.
// ---------------------------------------------------------------------------
`ifndef BLOCK_INDEX_LINKED_QUEUE_MACROS_SVH
`define BLOCK_INDEX_LINKED_QUEUE_MACROS_SVH

// same-cycle implication
`define BILQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BILQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/bilq_pkg.sv
// ---------------------------------------------------------------------------
// bilq_pkg
// Shared types and constants of the block index linked queue.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bilq_pkg;

  localparam int DEFAULT_NUM_BLOCKS = 1024;
  localparam int MAX_DEPTH          = 1024;
  localparam int IDX_W              = 10;
  localparam int LINK_W             = 11;
  localparam int OP_W               = 3;

  localparam logic [OP_W-1:0] OP_CLEAR        = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND_BLOCK = 3'd1;
  localparam logic [OP_W-1:0] OP_APPEND_RANGE = 3'd2;
  localparam logic [OP_W-1:0] OP_POLL         = 3'd3;
  localparam logic [OP_W-1:0] OP_WRITE_LINK   = 3'd4;

  localparam logic [LINK_W-1:0] LINK_END_MARK = 11'h400;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [IDX_W-1:0] block_index;
    logic [IDX_W-1:0] range_last;
    logic [IDX_W-1:0] link_target;
    logic             link_is_end;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] polled_block;
    logic             polled_valid;
    logic             link_error;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_MARK
  } state_t;

  typedef struct packed {
    logic capture;
    logic sweep;
    logic link_tail;
    logic append_done;
    logic poll_done;
    logic link_write;
    logic clear_list;
    logic rsp_load;
  } cmd_t;

  typedef struct packed {
    logic            sweep_last;
    logic [OP_W-1:0] opcode;
    logic            blk_ok;
    logic            last_ok;
    logic            nonempty;
    logic            rsp_free;
  } sts_t;

endpackage

### src/block_index_linked_queue.sv
// ---------------------------------------------------------------------------
// block_index_linked_queue
// FIFO of block indices threaded through a per-block link table.
// ---------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req) carries one operation per
//   transfer: clear, append block, append range, poll or write link.
//   rsp channel (rsp_valid / rsp_stall / rsp) returns exactly one result per
//   operation, in order; only a poll of a non-empty list gives a non-zero one.
//   Each request is captured, then executed; a valid append takes a further
//   end-mark step, since the single write port of the link table serves the
//   tail link (when the list is non-empty) and then the end mark. A poll
//   follows the registered read of the head link. A new request is taken
//   only in the idle state, once the last result has been loaded.
//   Reset: pointers clear at once, then all min(NUM_BLOCKS, 1024) entries
//   of the link table are swept to "contiguous", one entry per cycle, while
//   req_stall stays high.
//   A stalled result is held in the output register; the next request is
//   still taken and runs up to its result, which waits until rsp is free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_index_linked_queue #(
  parameter int NUM_BLOCKS = bilq_pkg::DEFAULT_NUM_BLOCKS
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bilq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output bilq_pkg::rsp_t rsp
);
  import bilq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bilq_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bilq_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

### src/bilq_datapath.sv
// ---------------------------------------------------------------------------
// bilq_datapath
// Link table, list pointers, item register and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module bilq_datapath #(
  parameter int NUM_BLOCKS = bilq_pkg::DEFAULT_NUM_BLOCKS
) (
  input  logic          clk,
  input  logic          rst,
  input  bilq_pkg::req_t req,
  input  bilq_pkg::cmd_t cmd,
  input  logic          rsp_stall,
  output bilq_pkg::sts_t sts,
  output logic          rsp_valid,
  output bilq_pkg::rsp_t rsp
);
  import bilq_pkg::*;

  localparam int TABLE_DEPTH = (NUM_BLOCKS < MAX_DEPTH) ? NUM_BLOCKS : MAX_DEPTH;
  localparam int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [LINK_W-1:0] TABLE_END = LINK_W'(TABLE_DEPTH);

  logic [LINK_W-1:0] link_mem [TABLE_DEPTH];
  logic [LINK_W-1:0] rd_link;
  req_t              item;
  logic [IDX_W-1:0]  head;
  logic [IDX_W-1:0]  tail;
  logic              nonempty;
  logic [AW-1:0]     sweep_cnt;

  logic [IDX_W-1:0]  last_sel;
  logic [IDX_W-1:0]  link_tgt;
  logic              link_end;
  logic [LINK_W-1:0] nx;
  logic              nx_ok;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [LINK_W-1:0] wr_data;
  rsp_t              poll_rsp;

  assign last_sel = (item.opcode == OP_APPEND_BLOCK) ? item.block_index : item.range_last;
  assign link_end = rd_link[LINK_W-1];
  assign link_tgt = rd_link[IDX_W-1:0];
  assign nx       = (link_tgt == '0) ? ({1'b0, head} + LINK_W'(1)) : {1'b0, link_tgt};
  assign nx_ok    = nx < TABLE_END;

  assign poll_rsp.polled_block = head;
  assign poll_rsp.polled_valid = 1'b1;
  assign poll_rsp.link_error   = !link_end && !nx_ok;

  assign sts.sweep_last = (sweep_cnt == AW'(TABLE_DEPTH - 1));
  assign sts.opcode     = item.opcode;
  assign sts.blk_ok     = {1'b0, item.block_index} < TABLE_END;
  assign sts.last_ok    = {1'b0, last_sel} < TABLE_END;
  assign sts.nonempty   = nonempty;
  assign sts.rsp_free   = !rsp_valid || !rsp_stall;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd.sweep) begin
      wr_en   = 1'b1;
      wr_addr = sweep_cnt;
    end else if (cmd.link_tail) begin
      wr_en   = 1'b1;
      wr_addr = tail[AW-1:0];
      wr_data = {1'b0, item.block_index};
    end else if (cmd.append_done) begin
      wr_en   = 1'b1;
      wr_addr = last_sel[AW-1:0];
      wr_data = LINK_END_MARK;
    end else if (cmd.link_write) begin
      wr_en   = 1'b1;
      wr_addr = item.block_index[AW-1:0];
      wr_data = item.link_is_end ? LINK_END_MARK : {1'b0, item.link_target};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    rd_link <= link_mem[head[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= sweep_cnt + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      tail     <= '0;
      nonempty <= 1'b0;
    end else if (cmd.clear_list) begin
      head     <= '0;
      tail     <= '0;
      nonempty <= 1'b0;
    end else if (cmd.append_done) begin
      if (!nonempty) begin
        head <= item.block_index;
      end
      nonempty <= 1'b1;
      tail     <= last_sel;
    end else if (cmd.poll_done) begin
      if (link_end || !nx_ok) begin
        nonempty <= 1'b0;
      end else begin
        head <= nx[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      rsp <= cmd.poll_done ? poll_rsp : '0;
    end
  end

endmodule

### src/bilq_controller.sv
// ---------------------------------------------------------------------------
// bilq_controller
// Sequencer for table sweep, item execution and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "block_index_linked_queue_macros.svh"

module bilq_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  bilq_pkg::sts_t sts,
  output bilq_pkg::cmd_t cmd
);
  import bilq_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = (state != ST_IDLE);
    case (state)
      ST_INIT: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts.opcode)
          OP_APPEND_BLOCK, OP_APPEND_RANGE: begin
            if (sts.blk_ok && sts.last_ok) begin
              cmd.link_tail = sts.nonempty;
              state_next    = ST_MARK;
            end else if (sts.rsp_free) begin
              cmd.rsp_load = 1'b1;
              state_next   = ST_IDLE;
            end
          end
          OP_CLEAR: begin
            if (sts.rsp_free) begin
              cmd.clear_list = 1'b1;
              cmd.rsp_load   = 1'b1;
              state_next     = ST_IDLE;
            end
          end
          OP_POLL: begin
            if (sts.rsp_free) begin
              cmd.poll_done = sts.nonempty;
              cmd.rsp_load  = 1'b1;
              state_next    = ST_IDLE;
            end
          end
          OP_WRITE_LINK: begin
            if (sts.rsp_free) begin
              cmd.link_write = sts.blk_ok;
              cmd.rsp_load   = 1'b1;
              state_next     = ST_IDLE;
            end
          end
          default: begin
            if (sts.rsp_free) begin
              cmd.rsp_load = 1'b1;
              state_next   = ST_IDLE;
            end
          end
        endcase
      end
      ST_MARK: begin
        if (sts.rsp_free) begin
          cmd.append_done = 1'b1;
          cmd.rsp_load    = 1'b1;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

  `BILQ_ASSERT_NOW(a_mark_after_exec, clk, rst, state == ST_MARK, $past(state) == ST_EXEC || $past(state) == ST_MARK, "end-mark step entered without execute")
  `BILQ_ASSERT_NOW(a_load_when_free, clk, rst, cmd.rsp_load, sts.rsp_free, "result loaded over an unaccepted result")
  `BILQ_ASSERT_NOW(a_one_writer, clk, rst, 1'b1, $onehot0({cmd.sweep, cmd.link_tail, cmd.append_done, cmd.link_write}), "competing table writes")
  `BILQ_ASSERT_NEXT(a_capture_exec, clk, rst, cmd.capture, state == ST_EXEC, "captured item not executed")

endmodule

### test/block_index_linked_queue_test.sv
// ---------------------------------------------------------------------------
// block_index_linked_queue_test
// Drives clear, append, range append, poll, link write and undefined opcodes
// into the block index queue. A directed table goes first, then weighted random traffic.
// Random idle gaps are applied on both channels. Every result transfer is checked field
// by field against a fixed row's hand-written result, else a local list and link table model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_index_linked_queue_test;
  import bilq_pkg::*;

  localparam int unsigned END_IDX =
    (DEFAULT_NUM_BLOCKS < MAX_DEPTH) ? DEFAULT_NUM_BLOCKS : MAX_DEPTH;
  localparam int unsigned RANDOM_OPS  = 1900;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned REPORT_MAX  = 10;
  localparam int unsigned DRAIN       = 20;

  localparam logic [OP_W-1:0] OP_NOP5 = 3'd5;
  localparam logic [OP_W-1:0] OP_NOP6 = 3'd6;
  localparam logic [OP_W-1:0] OP_NOP7 = 3'd7;

  localparam rsp_t NO_RESULT = '0;

  // one row of the directed table; fixed rows carry a hand-written result
  typedef struct packed {
    req_t op;
    logic fixed;
    rsp_t want;
  } step_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // model state
  logic [IDX_W-1:0]  q_head;
  logic [IDX_W-1:0]  q_tail;
  logic              q_busy;
  logic [LINK_W-1:0] link_mem [MAX_DEPTH];

  rsp_t        poll_results_due[$];
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;

  block_index_linked_queue dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #6 clk = ~clk;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [IDX_W-1:0] pick_block();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return IDX_W'($urandom_range(0, 31));
    if (r < 8) return IDX_W'($urandom_range(END_IDX - 24, END_IDX - 1));
    return IDX_W'($urandom);
  endfunction

  function automatic req_t req_of(logic [OP_W-1:0] opc, int unsigned blk,
                                  int unsigned last, int unsigned tgt,
                                  logic is_end);
    req_t r;
    r.opcode      = opc;
    r.block_index = IDX_W'(blk);
    r.range_last  = IDX_W'(last);
    r.link_target = IDX_W'(tgt);
    r.link_is_end = is_end;
    return r;
  endfunction

  function automatic rsp_t hit(int unsigned blk, logic err);
    rsp_t r;
    r.polled_block = IDX_W'(blk);
    r.polled_valid = 1'b1;
    r.link_error   = err;
    return r;
  endfunction

  function automatic void chain_after_tail(logic [IDX_W-1:0] first,
                                           logic [IDX_W-1:0] last);
    if (!q_busy) begin
      q_head = first;
      q_busy = 1'b1;
    end else begin
      link_mem[q_tail] = {1'b0, first};
    end
    q_tail         = last;
    link_mem[last] = LINK_END_MARK;
  endfunction

  function automatic rsp_t apply_op(req_t r);
    rsp_t              res;
    logic [LINK_W-1:0] ln;
    int unsigned       nxt;
    res = '0;
    case (r.opcode)
      OP_CLEAR: begin
        q_busy = 1'b0;
        q_head = '0;
        q_tail = '0;
      end
      OP_APPEND_BLOCK: begin
        if (r.block_index < END_IDX) chain_after_tail(r.block_index, r.block_index);
      end
      OP_APPEND_RANGE: begin
        if (r.block_index < END_IDX && r.range_last < END_IDX)
          chain_after_tail(r.block_index, r.range_last);
      end
      OP_POLL: begin
        if (q_busy) begin
          ln               = link_mem[q_head];
          res.polled_block = q_head;
          res.polled_valid = 1'b1;
          if ((ln & LINK_END_MARK) != '0) begin
            q_busy = 1'b0;
          end else begin
            nxt = (ln[IDX_W-1:0] == '0) ? int'(q_head) + 1 : int'(ln[IDX_W-1:0]);
            if (nxt < END_IDX) begin
              q_head = IDX_W'(nxt);
            end else begin
              res.link_error = 1'b1;
              q_busy         = 1'b0;
            end
          end
        end
      end
      OP_WRITE_LINK: begin
        if (r.block_index < END_IDX)
          link_mem[r.block_index] = r.link_is_end ? LINK_END_MARK : {1'b0, r.link_target};
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic req_t draw_op();
    req_t        r;
    int unsigned sel;
    sel           = $urandom_range(0, 99);
    r.opcode      = OP_POLL;
    r.block_index = pick_block();
    r.range_last  = IDX_W'($urandom);
    r.link_target = IDX_W'($urandom);
    r.link_is_end = 1'($urandom);
    if (sel < 2) begin
      r.opcode = OP_CLEAR;
    end else if (sel < 22) begin
      r.opcode = OP_APPEND_BLOCK;
    end else if (sel < 37) begin
      r.opcode = OP_APPEND_RANGE;
      if ($urandom_range(0, 3) != 0)
        r.range_last = (r.block_index > IDX_W'(END_IDX - 8)) ? IDX_W'(END_IDX - 1) :
                       r.block_index + IDX_W'($urandom_range(0, 6));
    end else if (sel < 72) begin
      r.opcode = OP_POLL;
    end else if (sel < 94) begin
      r.opcode      = OP_WRITE_LINK;
      r.link_is_end = ($urandom_range(0, 4) == 0);
      r.link_target = ($urandom_range(0, 4) < 2) ? '0 : pick_block();
    end else begin
      r.opcode = OP_W'($urandom_range(OP_NOP5, OP_NOP7));
    end
    return r;
  endfunction

  // holds the request until the transfer, then updates the model
  task automatic issue(input req_t r, input logic fixed, input rsp_t want);
    rsp_t got;
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    got = apply_op(r);
    poll_results_due.push_back(fixed ? want : got);
  endtask

  task automatic hold_off(input int unsigned n);
    if (n != 0) begin
      req_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    step_t plan[$];
    for (int k = 0; k < MAX_DEPTH; k++) link_mem[k] = '0;
    q_head = '0;
    q_tail = '0;
    q_busy = 1'b0;

    plan.push_back(step_t'{req_of(OP_POLL, 0, 0, 0, 0), 1'b1, NO_RESULT});
    plan.push_back(step_t'{req_of(OP_APPEND_BLOCK, 1023, 0, 0, 0), 1'b1, NO_RESULT});
    plan.push_back(step_t'{req_of(OP_POLL, 0, 0, 0, 0), 1'b1, hit(1023, 1'b0)});
    plan.push_back(step_t'{req_of(OP_POLL, 0, 0, 0, 0), 1'b1, NO_RESULT});
    // contiguous successor of the last block runs off the table
    plan.push_back(step_t'{req_of(OP_APPEND_BLOCK, 1023, 0, 0, 0), 1'b1, NO_RESULT});
    plan.push_back(step_t'{req_of(OP_APPEND_BLOCK, 5, 0, 0, 0), 1'b1, NO_RESULT});
    plan.push_back(step_t'{req_of(OP_WRITE_LINK, 1023, 0, 0, 0), 1'b1, NO_RESULT});
    plan.push_back(step_t'{req_of(OP_POLL, 0, 0, 0, 0), 1'b1, hit(1023, 1'b1)});
    plan.push_back(step_t'{req_of(OP_POLL, 0, 0, 0, 0), 1'b1, NO_RESULT});
    // appending block 0 leaves a zero link, read back as contiguous
    plan.push_back(step_t'{req_of(OP_APPEND_BLOCK, 9, 0, 0, 0), 1'b1, NO_RESULT});
    plan.push_back(step_t'{req_of(OP_APPEND_BLOCK, 0, 0, 0, 0), 1'b1, NO_RESULT});
    plan.push_back(step_t'{req_of(OP_POLL, 0, 0, 0, 0), 1'b1, hit(9, 1'b0)});
    plan.push_back(step_t'{req_of(OP_POLL, 0, 0, 0, 0), 1'b0, NO_RESULT});
    plan.push_back(step_t'{req_of(OP_CLEAR, 1023, 1023, 1023, 1), 1'b1, NO_RESULT});
    plan.push_back(step_t'{req_of(OP_APPEND_RANGE, 1020, 1023, 0, 0), 1'b1, NO_RESULT});
    plan.push_back(step_t'{req_of(OP_POLL, 0, 0, 0, 0), 1'b0, NO_RESULT});
    plan.push_back(step_t'{req_of(OP_WRITE_LINK, 1021, 0, 1023, 0), 1'b1, NO_RESULT});
    plan.push_back(step_t'{req_of(OP_POLL, 0, 0, 0, 0), 1'b0, NO_RESULT});
    plan.push_back(step_t'{req_of(OP_POLL, 0, 0, 0, 0), 1'b0, NO_RESULT});
    plan.push_back(step_t'{req_of(OP_WRITE_LINK, 0, 0, 1023, 1), 1'b1, NO_RESULT});
    plan.push_back(step_t'{req_of(OP_NOP5, 0, 0, 0, 0), 1'b1, NO_RESULT});
    plan.push_back(step_t'{req_of(OP_NOP6, 1023, 1023, 1023, 1), 1'b1, NO_RESULT});
    plan.push_back(step_t'{req_of(OP_NOP7, 0, 0, 0, 0), 1'b1, NO_RESULT});
    plan.push_back(step_t'{req_of(OP_APPEND_RANGE, 0, 0, 0, 0), 1'b1, NO_RESULT});
    plan.push_back(step_t'{req_of(OP_POLL, 0, 0, 0, 0), 1'b0, NO_RESULT});

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[k]) begin
      issue(plan[k].op, plan[k].fixed, plan[k].want);
      hold_off(idle_len());
    end

    // back-to-back stretches mixed with idle gaps
    for (int unsigned i = 0; i < RANDOM_OPS; i++) begin
      issue(draw_op(), 1'b0, NO_RESULT);
      hold_off((i % 300 < 60) ? 0 : idle_len());
    end
    req_valid <= 1'b0;

    while (poll_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // result back-pressure: short bursts of stall between free stretches
  initial begin
    int unsigned n;
    forever begin
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 4))
        @(posedge clk);
      n = idle_len();
      if (n != 0) begin
        rsp_stall <= 1'b1;
        repeat (n) @(posedge clk);
        rsp_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (poll_results_due.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display("unexpected transfer: block=%0d valid=%b error=%b",
                   rsp.polled_block, rsp.polled_valid, rsp.link_error);
      end else begin
        want = poll_results_due.pop_front();
        if (rsp.polled_block !== want.polled_block ||
            rsp.polled_valid !== want.polled_valid ||
            rsp.link_error !== want.link_error) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display("mismatch: block exp %0d got %0d, valid exp %b got %b, error exp %b got %b",
                     want.polled_block, rsp.polled_block, want.polled_valid,
                     rsp.polled_valid, want.link_error, rsp.link_error);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

endmodule
